// ===== rtl/itt_pkg.sv =====
package itt_pkg;

    localparam int NUM_TIMERS_DEF = 8;
    localparam int TIME_BITS_DEF  = 48;
    localparam int MAX_RESULTS    = 8;
    localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

    localparam int FIELD_BITS = 48;
    localparam int MIN_BITS   = 24;
    localparam int NUM_BITS   = 4;
    localparam int OP_BITS    = 3;
    localparam logic [MIN_BITS-1:0] MIN_RESET = 24'd1000;

    // input request layout
    localparam int IN_BITS = 152;
    localparam int IN_OP_LO  = 0;
    localparam int IN_NUM_LO = IN_OP_LO + OP_BITS;
    localparam int IN_PER_LO = IN_NUM_LO + NUM_BITS;
    localparam int IN_LIM_LO = IN_PER_LO + FIELD_BITS;
    localparam int IN_NOW_LO = IN_LIM_LO + FIELD_BITS;

    // result layout
    localparam int OUT_BITS  = 56;
    localparam int KIND_BITS = 2;

    localparam logic [OP_BITS-1:0] OP_START  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_STOP   = 3'd1;
    localparam logic [OP_BITS-1:0] OP_RESUME = 3'd2;
    localparam logic [OP_BITS-1:0] OP_QUERY  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_TICK   = 3'd4;

    typedef enum logic [1:0] {
        KIND_REPLY,
        KIND_INTERVAL,
        KIND_TIMEOUT
    } t_kind;

    typedef enum logic [1:0] {
        RC_OK,
        RC_WRONG,
        RC_BAD_ID
    } t_reply;

    typedef enum logic [1:0] {
        ST_UNKNOWN,
        ST_STARTED,
        ST_STOPPED,
        ST_TIMEDOUT
    } t_status;

    typedef struct packed {
        t_kind                  kind;
        logic [NUM_BITS-1:0]    timer;
        t_reply                 code;
        t_status                status;
        logic [FIELD_BITS-1:0]  elapsed;
        logic                   last;
    } t_result;

    typedef struct packed {
        logic status;
        logic period;
        logic limit;
        logic elapsed;
        logic mark;
        logic npd;
        logic tod;
    } t_bank_we;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_TO,
        S_T_PD,
        S_T_ADV,
        S_T_CHK,
        S_ST_PER,
        S_ST_LIM,
        S_ST_NPD,
        S_ST_TOD,
        S_SP_SUB,
        S_SP_ADD,
        S_RS_SUB,
        S_RS_NPD,
        S_RS_TOD,
        S_Q_SUB,
        S_Q_ADD,
        S_EMIT
    } t_state;

endpackage

// ===== rtl/interval_timeout_timer_bank.sv =====
// bank of NUM_TIMERS interval/timeout timers, numbered from 1
// request channel (s_axis): one command per request - start, stop, resume,
// query or tick - with the current microsecond time in now_us
// result channel (m_axis): tuser carries the kind (reply, interval event,
// timeout event), tlast marks the final result of a request
// configuration channel (cfg): minimum period, taken at any time, meant to be
// written while the bank is idle
// a command passes through the shared add/subtract unit and gives one reply;
// a tick walks the timers one at a time, ending early after MAX_RESULTS events,
// then flushes the final event
// tready is low while a request is being worked on
// invalid timer numbers give a bad-id reply; unused opcodes and ticks with no
// event give nothing
// results sit in an output register; while the receiver stalls, the scan holds
// at the timer that has an event waiting
// after reset all timers are timed out and the minimum period is 1000 us
module interval_timeout_timer_bank #(
    parameter int NUM_TIMERS = itt_pkg::NUM_TIMERS_DEF,
    parameter int TIME_BITS  = itt_pkg::TIME_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // opcode, timer_number, period_us, limit_us, now_us, zero pad
    input  logic [itt_pkg::IN_BITS-1:0]     i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // event_timer, reply_code, timer_status, elapsed_out_us
    output logic [itt_pkg::OUT_BITS-1:0]    o_m_axis_tdata,
    // kind
    output logic [itt_pkg::KIND_BITS-1:0]   o_m_axis_tuser,
    output logic                            o_m_axis_tlast,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [itt_pkg::MIN_BITS-1:0]    i_cfg_data
);
    import itt_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic [MIN_BITS-1:0]   r_min;
    logic                  r_out_valid;
    t_result               r_out;

    logic                  res_valid, res_ready;
    t_result               res;
    logic [IDX_W-1:0]      idx;
    t_bank_we              we;
    t_status               wr_status, rd_status;
    logic [TIME_BITS-1:0]  wr_period, wr_limit, wr_elapsed, wr_mark, wr_npd, wr_tod;
    logic [TIME_BITS-1:0]  rd_period, rd_limit, rd_elapsed, rd_mark, rd_npd, rd_tod;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_RESET;
        end else if (i_cfg_valid) begin
            r_min <= i_cfg_data;
        end
    end

    assign res_ready = ~r_out_valid | i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.elapsed, r_out.status, r_out.code, r_out.timer};
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;

    itt_ctrl #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_BITS  (TIME_BITS),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_s_axis_tvalid),
        .o_req_ready  (o_s_axis_tready),
        .i_req_data   (i_s_axis_tdata),
        .i_min        (r_min),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_idx        (idx),
        .o_we         (we),
        .o_wr_status  (wr_status),
        .o_wr_period  (wr_period),
        .o_wr_limit   (wr_limit),
        .o_wr_elapsed (wr_elapsed),
        .o_wr_mark    (wr_mark),
        .o_wr_npd     (wr_npd),
        .o_wr_tod     (wr_tod),
        .i_rd_status  (rd_status),
        .i_rd_period  (rd_period),
        .i_rd_limit   (rd_limit),
        .i_rd_elapsed (rd_elapsed),
        .i_rd_mark    (rd_mark),
        .i_rd_npd     (rd_npd),
        .i_rd_tod     (rd_tod)
    );

    itt_bank #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_BITS  (TIME_BITS),
        .IDX_W      (IDX_W)
    ) u_bank (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_idx        (idx),
        .i_we         (we),
        .i_wr_status  (wr_status),
        .i_wr_period  (wr_period),
        .i_wr_limit   (wr_limit),
        .i_wr_elapsed (wr_elapsed),
        .i_wr_mark    (wr_mark),
        .i_wr_npd     (wr_npd),
        .i_wr_tod     (wr_tod),
        .o_rd_status  (rd_status),
        .o_rd_period  (rd_period),
        .o_rd_limit   (rd_limit),
        .o_rd_elapsed (rd_elapsed),
        .o_rd_mark    (rd_mark),
        .o_rd_npd     (rd_npd),
        .o_rd_tod     (rd_tod)
    );

endmodule

// ===== rtl/itt_alu.sv =====
module itt_alu #(
    parameter int W = 48
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_sub,
    output logic [W-1:0] o_sum,
    output logic         o_below
);

    logic [W:0] w_full;
    logic [W-1:0] w_b;

    assign w_b    = i_sub ? ~i_b : i_b;
    assign w_full = {1'b0, i_a} + {1'b0, w_b} + {{W{1'b0}}, i_sub};
    assign o_sum  = w_full[W-1:0];
    // unsigned a below b, valid when subtracting
    assign o_below = i_sub & ~w_full[W];

endmodule

// ===== rtl/itt_bank.sv =====
module itt_bank #(
    parameter int NUM_TIMERS = 8,
    parameter int TIME_BITS  = 48,
    parameter int IDX_W      = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IDX_W-1:0]      i_idx,
    input  itt_pkg::t_bank_we     i_we,
    input  itt_pkg::t_status      i_wr_status,
    input  logic [TIME_BITS-1:0]  i_wr_period,
    input  logic [TIME_BITS-1:0]  i_wr_limit,
    input  logic [TIME_BITS-1:0]  i_wr_elapsed,
    input  logic [TIME_BITS-1:0]  i_wr_mark,
    input  logic [TIME_BITS-1:0]  i_wr_npd,
    input  logic [TIME_BITS-1:0]  i_wr_tod,
    output itt_pkg::t_status      o_rd_status,
    output logic [TIME_BITS-1:0]  o_rd_period,
    output logic [TIME_BITS-1:0]  o_rd_limit,
    output logic [TIME_BITS-1:0]  o_rd_elapsed,
    output logic [TIME_BITS-1:0]  o_rd_mark,
    output logic [TIME_BITS-1:0]  o_rd_npd,
    output logic [TIME_BITS-1:0]  o_rd_tod
);
    import itt_pkg::*;

    t_status              r_status  [NUM_TIMERS];
    logic [TIME_BITS-1:0] r_period  [NUM_TIMERS];
    logic [TIME_BITS-1:0] r_limit   [NUM_TIMERS];
    logic [TIME_BITS-1:0] r_elapsed [NUM_TIMERS];
    logic [TIME_BITS-1:0] r_mark    [NUM_TIMERS];
    logic [TIME_BITS-1:0] r_npd     [NUM_TIMERS];
    logic [TIME_BITS-1:0] r_tod     [NUM_TIMERS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TIMERS; k++) begin
                r_status[k]  <= ST_TIMEDOUT;
                r_period[k]  <= '0;
                r_limit[k]   <= '0;
                r_elapsed[k] <= '0;
                r_mark[k]    <= '0;
                r_npd[k]     <= '0;
                r_tod[k]     <= '0;
            end
        end else begin
            if (i_we.status)  r_status[i_idx]  <= i_wr_status;
            if (i_we.period)  r_period[i_idx]  <= i_wr_period;
            if (i_we.limit)   r_limit[i_idx]   <= i_wr_limit;
            if (i_we.elapsed) r_elapsed[i_idx] <= i_wr_elapsed;
            if (i_we.mark)    r_mark[i_idx]    <= i_wr_mark;
            if (i_we.npd)     r_npd[i_idx]     <= i_wr_npd;
            if (i_we.tod)     r_tod[i_idx]     <= i_wr_tod;
        end
    end

    assign o_rd_status  = r_status[i_idx];
    assign o_rd_period  = r_period[i_idx];
    assign o_rd_limit   = r_limit[i_idx];
    assign o_rd_elapsed = r_elapsed[i_idx];
    assign o_rd_mark    = r_mark[i_idx];
    assign o_rd_npd     = r_npd[i_idx];
    assign o_rd_tod     = r_tod[i_idx];

endmodule

// ===== rtl/itt_ctrl.sv =====
module itt_ctrl #(
    parameter int NUM_TIMERS = 8,
    parameter int TIME_BITS  = 48,
    parameter int IDX_W      = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  logic [itt_pkg::IN_BITS-1:0]     i_req_data,
    input  logic [itt_pkg::MIN_BITS-1:0]    i_min,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output itt_pkg::t_result                o_res,
    output logic [IDX_W-1:0]                o_idx,
    output itt_pkg::t_bank_we               o_we,
    output itt_pkg::t_status                o_wr_status,
    output logic [TIME_BITS-1:0]            o_wr_period,
    output logic [TIME_BITS-1:0]            o_wr_limit,
    output logic [TIME_BITS-1:0]            o_wr_elapsed,
    output logic [TIME_BITS-1:0]            o_wr_mark,
    output logic [TIME_BITS-1:0]            o_wr_npd,
    output logic [TIME_BITS-1:0]            o_wr_tod,
    input  itt_pkg::t_status                i_rd_status,
    input  logic [TIME_BITS-1:0]            i_rd_period,
    input  logic [TIME_BITS-1:0]            i_rd_limit,
    input  logic [TIME_BITS-1:0]            i_rd_elapsed,
    input  logic [TIME_BITS-1:0]            i_rd_mark,
    input  logic [TIME_BITS-1:0]            i_rd_npd,
    input  logic [TIME_BITS-1:0]            i_rd_tod
);
    import itt_pkg::*;

    function automatic logic [TIME_BITS-1:0] from_field(input logic [FIELD_BITS-1:0] v);
        logic [FIELD_BITS+TIME_BITS-1:0] w;
        w = {{TIME_BITS{1'b0}}, v};
        return w[TIME_BITS-1:0];
    endfunction

    function automatic logic [FIELD_BITS-1:0] to_field(input logic [TIME_BITS-1:0] v);
        logic [FIELD_BITS+TIME_BITS-1:0] w;
        w = {{FIELD_BITS{1'b0}}, v};
        return w[FIELD_BITS-1:0];
    endfunction

    function automatic t_result mk_res(input t_kind k, input logic [NUM_BITS-1:0] t,
                                       input t_reply c, input t_status s,
                                       input logic [FIELD_BITS-1:0] e);
        t_result r;
        r.kind    = k;
        r.timer   = t;
        r.code    = c;
        r.status  = s;
        r.elapsed = e;
        r.last    = 1'b0;
        return r;
    endfunction

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [TIME_BITS-1:0]   r_per, n_per;
    logic [TIME_BITS-1:0]   r_lim, n_lim;
    logic [TIME_BITS-1:0]   r_now, n_now;
    logic [TIME_BITS-1:0]   r_acc, n_acc;
    t_result                r_held, n_held;
    logic                   r_held_valid, n_held_valid;

    logic [TIME_BITS-1:0]   alu_a, alu_b, alu_sum;
    logic                   alu_sub, alu_below, reached;
    logic [TIME_BITS-1:0]   min_ext;
    logic [TIME_BITS+MIN_BITS-1:0] min_wide;
    logic [OP_BITS-1:0]     in_op;
    logic [NUM_BITS-1:0]    in_num, in_num_m1, tnum;
    logic                   num_ok;
    logic                   ev_fire, go_next, blocked;
    t_result                ev;

    itt_alu #(.W(TIME_BITS)) u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_sum   (alu_sum),
        .o_below (alu_below)
    );

    assign min_wide  = {{TIME_BITS{1'b0}}, i_min};
    assign min_ext   = min_wide[TIME_BITS-1:0];
    assign reached   = ~alu_sum[TIME_BITS-1];
    assign in_op     = i_req_data[IN_OP_LO +: OP_BITS];
    assign in_num    = i_req_data[IN_NUM_LO +: NUM_BITS];
    assign in_num_m1 = in_num - 4'd1;
    assign num_ok    = (in_num != '0) && (in_num <= NUM_BITS'(NUM_TIMERS));
    assign tnum      = NUM_BITS'(r_idx) + 4'd1;
    assign o_idx     = r_idx;
    assign o_req_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_held_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_held_valid <= n_held_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_per  <= n_per;
        r_lim  <= n_lim;
        r_now  <= n_now;
        r_acc  <= n_acc;
        r_held <= n_held;
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_per        = r_per;
        n_lim        = r_lim;
        n_now        = r_now;
        n_acc        = r_acc;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        alu_a        = r_now;
        alu_b        = r_acc;
        alu_sub      = 1'b0;
        o_we         = '0;
        o_wr_status  = ST_STARTED;
        o_wr_period  = r_per;
        o_wr_limit   = r_lim;
        o_wr_elapsed = alu_sum;
        o_wr_mark    = r_now;
        o_wr_npd     = alu_sum;
        o_wr_tod     = alu_sum;
        o_res_valid  = 1'b0;
        o_res        = r_held;
        ev_fire      = 1'b0;
        go_next      = 1'b0;
        blocked      = 1'b0;
        ev           = mk_res(KIND_INTERVAL, tnum, RC_OK, ST_STARTED, '0);

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_per = from_field(i_req_data[IN_PER_LO +: FIELD_BITS]);
                    n_lim = from_field(i_req_data[IN_LIM_LO +: FIELD_BITS]);
                    n_now = from_field(i_req_data[IN_NOW_LO +: FIELD_BITS]);
                    n_idx = in_num_m1[IDX_W-1:0];
                    if (in_op == OP_TICK) begin
                        n_idx        = '0;
                        n_cnt        = '0;
                        n_held_valid = 1'b0;
                        n_state      = S_T_TO;
                    end else if (in_op > OP_TICK) begin
                        n_state = S_IDLE;
                    end else if (!num_ok) begin
                        n_held      = mk_res(KIND_REPLY, in_num, RC_BAD_ID, ST_UNKNOWN, '0);
                        n_state     = S_EMIT;
                    end else begin
                        case (in_op)
                            OP_START:  n_state = S_ST_PER;
                            OP_STOP:   n_state = S_SP_SUB;
                            OP_RESUME: n_state = S_RS_SUB;
                            default:   n_state = S_Q_SUB;
                        endcase
                    end
                end
            end
            S_T_TO: begin
                alu_a   = r_now;
                alu_b   = i_rd_tod;
                alu_sub = 1'b1;
                if (i_rd_status != ST_STARTED) begin
                    go_next = 1'b1;
                end else if (i_rd_limit != '0 && reached) begin
                    o_we.status  = 1'b1;
                    o_wr_status  = ST_TIMEDOUT;
                    o_we.elapsed = 1'b1;
                    o_wr_elapsed = i_rd_limit;
                    ev_fire      = 1'b1;
                    ev           = mk_res(KIND_TIMEOUT, tnum, RC_OK, ST_TIMEDOUT, '0);
                    go_next      = 1'b1;
                end else if (i_rd_period != '0) begin
                    n_state = S_T_PD;
                end else begin
                    go_next = 1'b1;
                end
            end
            S_T_PD: begin
                alu_a   = r_now;
                alu_b   = i_rd_npd;
                alu_sub = 1'b1;
                if (reached) begin
                    n_state = S_T_ADV;
                end else begin
                    go_next = 1'b1;
                end
            end
            S_T_ADV: begin
                alu_a   = i_rd_npd;
                alu_b   = i_rd_period;
                o_we.npd = 1'b1;
                n_state = S_T_CHK;
            end
            S_T_CHK: begin
                alu_a   = r_now;
                alu_b   = i_rd_npd;
                alu_sub = 1'b1;
                ev_fire = ~reached;
                go_next = 1'b1;
            end
            S_ST_PER: begin
                alu_a   = r_per;
                alu_b   = min_ext;
                alu_sub = 1'b1;
                if (r_per != '0 && alu_below) n_per = min_ext;
                n_state = S_ST_LIM;
            end
            S_ST_LIM: begin
                alu_a   = r_lim;
                alu_b   = min_ext;
                alu_sub = 1'b1;
                if (r_lim != '0 && alu_below) n_lim = min_ext;
                n_state = S_ST_NPD;
            end
            S_ST_NPD: begin
                alu_a   = r_now;
                alu_b   = r_per;
                n_acc   = (r_per != '0) ? alu_sum : '0;
                n_state = S_ST_TOD;
            end
            S_ST_TOD: begin
                alu_a        = r_now;
                alu_b        = r_lim;
                o_we         = '1;
                o_wr_elapsed = '0;
                o_wr_npd     = r_acc;
                o_wr_tod     = (r_lim != '0) ? alu_sum : '0;
                n_held = mk_res(KIND_REPLY, tnum,
                                (i_rd_status == ST_STARTED) ? RC_WRONG : RC_OK,
                                ST_STARTED, '0);
                n_state = S_EMIT;
            end
            S_SP_SUB: begin
                alu_a   = r_now;
                alu_b   = i_rd_mark;
                alu_sub = 1'b1;
                n_acc   = alu_sum;
                if (i_rd_status != ST_STARTED) begin
                    n_held  = mk_res(KIND_REPLY, tnum, RC_WRONG, i_rd_status, '0);
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SP_ADD;
                end
            end
            S_SP_ADD: begin
                alu_a        = r_acc;
                alu_b        = i_rd_elapsed;
                o_we.elapsed = 1'b1;
                o_we.mark    = 1'b1;
                o_we.status  = 1'b1;
                o_wr_status  = ST_STOPPED;
                n_held  = mk_res(KIND_REPLY, tnum, RC_OK, ST_STOPPED, '0);
                n_state = S_EMIT;
            end
            S_RS_SUB: begin
                alu_a   = r_now;
                alu_b   = i_rd_mark;
                alu_sub = 1'b1;
                n_acc   = alu_sum;
                if (i_rd_status != ST_STOPPED) begin
                    n_held  = mk_res(KIND_REPLY, tnum, RC_WRONG, i_rd_status, '0);
                    n_state = S_EMIT;
                end else begin
                    n_state = S_RS_NPD;
                end
            end
            S_RS_NPD: begin
                alu_a    = i_rd_npd;
                alu_b    = r_acc;
                o_we.npd = (i_rd_period != '0);
                n_state  = S_RS_TOD;
            end
            S_RS_TOD: begin
                alu_a       = i_rd_tod;
                alu_b       = r_acc;
                o_we.tod    = (i_rd_limit != '0);
                o_we.mark   = 1'b1;
                o_we.status = 1'b1;
                o_wr_status = ST_STARTED;
                n_held  = mk_res(KIND_REPLY, tnum, RC_OK, ST_STARTED, '0);
                n_state = S_EMIT;
            end
            S_Q_SUB: begin
                alu_a   = r_now;
                alu_b   = i_rd_mark;
                alu_sub = 1'b1;
                n_acc   = alu_sum;
                if (i_rd_status != ST_STARTED) begin
                    n_held  = mk_res(KIND_REPLY, tnum, RC_OK, i_rd_status,
                                     to_field(i_rd_elapsed));
                    n_state = S_EMIT;
                end else begin
                    n_state = S_Q_ADD;
                end
            end
            S_Q_ADD: begin
                alu_a   = r_acc;
                alu_b   = i_rd_elapsed;
                n_held  = mk_res(KIND_REPLY, tnum, RC_OK, ST_STARTED, to_field(alu_sum));
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
                o_res.last  = 1'b1;
                if (i_res_ready) begin
                    n_held_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a new event pushes the held one out, so the final one can carry last
        if (ev_fire) begin
            o_res_valid = r_held_valid;
            blocked     = r_held_valid & ~i_res_ready;
            if (blocked) begin
                o_we    = '0;
                go_next = 1'b0;
            end else begin
                n_held       = ev;
                n_held_valid = 1'b1;
                n_cnt        = r_cnt + CNT_W'(1);
            end
        end

        if (go_next) begin
            if (ev_fire && r_cnt == CNT_W'(MAX_RESULTS - 1)) begin
                n_state = S_EMIT;
            end else if (r_idx == IDX_W'(NUM_TIMERS - 1)) begin
                n_state = n_held_valid ? S_EMIT : S_IDLE;
            end else begin
                n_idx   = r_idx + IDX_W'(1);
                n_state = S_T_TO;
            end
        end
    end

endmodule

// ===== rtl/itt_checker.sv =====
module itt_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            o_s_axis_tready,
    input  logic [itt_pkg::IN_BITS-1:0]     i_s_axis_tdata,
    input  logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic [itt_pkg::OUT_BITS-1:0]    o_m_axis_tdata,
    input  logic [itt_pkg::KIND_BITS-1:0]   o_m_axis_tuser,
    input  logic                            o_m_axis_tlast,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [itt_pkg::MIN_BITS-1:0]    i_cfg_data
);
    import itt_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // an unfinished tick keeps the request side closed
    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("request taken before the final result");

    // a taken start request leaves ready low in the next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready
            && i_s_axis_tdata[IN_OP_LO +: OP_BITS] == OP_START |=> !o_s_axis_tready)
        else $error("ready right after a start request");

    // events name a nonzero timer and carry a zero code
    a_event_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != KIND_REPLY |->
            o_m_axis_tdata[3:0] != 4'd0 && o_m_axis_tdata[5:4] == RC_OK)
        else $error("malformed event");

endmodule

bind interval_timeout_timer_bank itt_checker u_itt_checker (.*);

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import itt_pkg::*;

    localparam int NUM_TIMERS = NUM_TIMERS_DEF;
    localparam logic [OP_BITS-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_BITS-1:0] OP_UNUSED_HI = 3'd7;
    localparam int SETTLE_CYCLES = 4 * NUM_TIMERS + 16;
    localparam int CYCLE_LIMIT   = 300000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    req_valid = 1'b0;
    logic                    req_ready;
    logic [IN_BITS-1:0]      req_data = '0;
    logic                    res_valid;
    logic                    res_ready = 1'b0;
    logic [OUT_BITS-1:0]     res_data;
    logic [KIND_BITS-1:0]    res_kind;
    logic                    res_last;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [MIN_BITS-1:0]     cfg_data = '0;

    // predicted bank state, timers numbered from 1
    t_status                 timer_state  [1:NUM_TIMERS];
    logic [FIELD_BITS-1:0]   period_of    [1:NUM_TIMERS];
    logic [FIELD_BITS-1:0]   limit_of     [1:NUM_TIMERS];
    logic [FIELD_BITS-1:0]   run_total    [1:NUM_TIMERS];
    logic [FIELD_BITS-1:0]   mark_at      [1:NUM_TIMERS];
    logic [FIELD_BITS-1:0]   next_beat    [1:NUM_TIMERS];
    logic [FIELD_BITS-1:0]   timeout_at   [1:NUM_TIMERS];
    logic [MIN_BITS-1:0]     min_period;

    t_result                 due_results[$];
    logic [FIELD_BITS-1:0]   clock_us;
    int                      burst_left = 0;
    int                      live_items = 0;
    int                      ignored_items = 0;
    int                      results_checked = 0;
    int                      interval_events = 0;
    int                      timeout_events = 0;
    int                      late_skips = 0;
    int                      min_settings = 1;
    int                      error_count = 0;
    int                      cycle_count = 0;
    logic [15:0]             stall_pattern = 16'hFFFF;
    logic [5:0]              stall_phase = '0;

    interval_timeout_timer_bank u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_data),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .o_m_axis_tuser  (res_kind),
        .o_m_axis_tlast  (res_last),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     due_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver stall pattern, renewed whenever the stall phase counter wraps
    always @(posedge clk) begin
        if (stall_phase == 0) begin
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                          : (16'($urandom()) | 16'h0001);
        end
        res_ready   <= stall_pattern[stall_phase[3:0]];
        stall_phase <= stall_phase + 1'b1;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge clk) begin : check_results
        t_result want;
        if (rst_n && res_valid && res_ready) begin
            if (due_results.size() == 0) begin
                report_mismatch("result with nothing due",
                                64'({res_last, res_kind, res_data}), '0);
            end else begin
                want = due_results.pop_front();
                if (res_kind !== want.kind)
                    report_mismatch("kind", 64'(res_kind), 64'(want.kind));
                if (res_data[3:0] !== want.timer)
                    report_mismatch("event_timer", 64'(res_data[3:0]), 64'(want.timer));
                if (res_data[5:4] !== want.code)
                    report_mismatch("reply_code", 64'(res_data[5:4]), 64'(want.code));
                if (res_data[7:6] !== want.status)
                    report_mismatch("timer_status", 64'(res_data[7:6]), 64'(want.status));
                if (res_data[55:8] !== want.elapsed)
                    report_mismatch("elapsed_out_us", 64'(res_data[55:8]),
                                    64'(want.elapsed));
                if (res_last !== want.last)
                    report_mismatch("last", 64'(res_last), 64'(want.last));
                results_checked++;
            end
        end
    end

    function automatic logic deadline_hit(input logic [FIELD_BITS-1:0] now_v,
                                          input logic [FIELD_BITS-1:0] due_v);
        logic [FIELD_BITS-1:0] diff;
        diff = now_v - due_v;
        return !diff[FIELD_BITS-1];
    endfunction

    function automatic logic [FIELD_BITS-1:0] lift_to_minimum(input logic [FIELD_BITS-1:0] v);
        if (v != 0 && v < FIELD_BITS'(min_period))
            return FIELD_BITS'(min_period);
        return v;
    endfunction

    task automatic queue_result(input t_kind k, input logic [3:0] tmr, input t_reply c,
                                input t_status s, input logic [FIELD_BITS-1:0] el,
                                input logic lst);
        t_result r;
        r.kind    = k;
        r.timer   = tmr;
        r.code    = c;
        r.status  = s;
        r.elapsed = el;
        r.last    = lst;
        due_results.push_back(r);
    endtask

    task automatic clear_timer_bank();
        min_period = MIN_RESET;
        for (int idx = 1; idx <= NUM_TIMERS; idx++) begin
            timer_state[idx] = ST_TIMEDOUT;
            period_of[idx]   = '0;
            limit_of[idx]    = '0;
            run_total[idx]   = '0;
            mark_at[idx]     = '0;
            next_beat[idx]   = '0;
            timeout_at[idx]  = '0;
        end
    endtask

    task automatic advance_timer_bank(input logic [OP_BITS-1:0] op, input logic [3:0] num,
                                      input logic [FIELD_BITS-1:0] per,
                                      input logic [FIELD_BITS-1:0] lim,
                                      input logic [FIELD_BITS-1:0] now_v);
        int n;
        int idx;
        t_result r;
        t_reply code;
        logic [FIELD_BITS-1:0] paused;
        logic [FIELD_BITS-1:0] el;
        if (op == OP_TICK) begin
            n = 0;
            for (idx = 1; idx <= NUM_TIMERS && n < MAX_RESULTS; idx++) begin
                if (timer_state[idx] == ST_STARTED) begin
                    if (limit_of[idx] != 0 && deadline_hit(now_v, timeout_at[idx])) begin
                        timer_state[idx] = ST_TIMEDOUT;
                        run_total[idx]   = limit_of[idx];
                        queue_result(KIND_TIMEOUT, 4'(idx), RC_OK, ST_TIMEDOUT, '0, 1'b0);
                        n++;
                        timeout_events++;
                    end else if (period_of[idx] != 0
                                 && deadline_hit(now_v, next_beat[idx])) begin
                        next_beat[idx] = next_beat[idx] + period_of[idx];
                        if (!deadline_hit(now_v, next_beat[idx])) begin
                            queue_result(KIND_INTERVAL, 4'(idx), RC_OK, ST_STARTED, '0, 1'b0);
                            n++;
                            interval_events++;
                        end else begin
                            late_skips++;
                        end
                    end
                end
            end
            if (n > 0) begin
                r = due_results.pop_back();
                r.last = 1'b1;
                due_results.push_back(r);
            end
        end else if (op < OP_TICK) begin
            if (num == 0 || num > NUM_TIMERS) begin
                queue_result(KIND_REPLY, num, RC_BAD_ID, ST_UNKNOWN, '0, 1'b1);
            end else begin
                idx = num;
                case (op)
                    OP_START: begin
                        code = (timer_state[idx] == ST_STARTED) ? RC_WRONG : RC_OK;
                        period_of[idx]   = lift_to_minimum(per);
                        limit_of[idx]    = lift_to_minimum(lim);
                        run_total[idx]   = '0;
                        mark_at[idx]     = now_v;
                        next_beat[idx]   = (period_of[idx] != 0) ? now_v + period_of[idx] : '0;
                        timeout_at[idx]  = (limit_of[idx] != 0) ? now_v + limit_of[idx] : '0;
                        timer_state[idx] = ST_STARTED;
                        queue_result(KIND_REPLY, num, code, ST_STARTED, '0, 1'b1);
                    end
                    OP_STOP: begin
                        code = RC_WRONG;
                        if (timer_state[idx] == ST_STARTED) begin
                            run_total[idx]   = now_v - mark_at[idx] + run_total[idx];
                            mark_at[idx]     = now_v;
                            timer_state[idx] = ST_STOPPED;
                            code = RC_OK;
                        end
                        queue_result(KIND_REPLY, num, code, timer_state[idx], '0, 1'b1);
                    end
                    OP_RESUME: begin
                        code = RC_WRONG;
                        if (timer_state[idx] == ST_STOPPED) begin
                            paused = now_v - mark_at[idx];
                            if (period_of[idx] != 0)
                                next_beat[idx] = next_beat[idx] + paused;
                            if (limit_of[idx] != 0)
                                timeout_at[idx] = timeout_at[idx] + paused;
                            mark_at[idx]     = now_v;
                            timer_state[idx] = ST_STARTED;
                            code = RC_OK;
                        end
                        queue_result(KIND_REPLY, num, code, timer_state[idx], '0, 1'b1);
                    end
                    default: begin
                        el = run_total[idx];
                        if (timer_state[idx] == ST_STARTED)
                            el = now_v - mark_at[idx] + el;
                        queue_result(KIND_REPLY, num, RC_OK, timer_state[idx], el, 1'b1);
                    end
                endcase
            end
        end
    endtask

    task automatic send_request(input logic [OP_BITS-1:0] op, input logic [3:0] num,
                                input logic [FIELD_BITS-1:0] per,
                                input logic [FIELD_BITS-1:0] lim,
                                input logic [FIELD_BITS-1:0] now_v);
        int gap;
        if (burst_left == 0) begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 30)
                                                     : $urandom_range(1, 6);
        end
        burst_left--;
        req_valid <= 1'b1;
        req_data  <= {1'b0, now_v, lim, per, num, op};
        do @(posedge clk); while (!req_ready);
        advance_timer_bank(op, num, per, lim, now_v);
        if (op > OP_TICK)
            ignored_items++;
        else
            live_items++;
    endtask

    // let every outstanding result drain, then allow a tick scan to finish
    task automatic wait_bank_idle();
        req_valid <= 1'b0;
        burst_left = 0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_minimum_period(input logic [MIN_BITS-1:0] value);
        wait_bank_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        min_period = value;
        min_settings++;
    endtask

    task automatic test_reset_state();
        logic [FIELD_BITS-1:0] t0;
        t0 = 48'd5000;
        send_request(OP_QUERY, 4'd1, '0, '0, t0);
        send_request(OP_QUERY, 4'd8, '0, '0, t0);
        send_request(OP_QUERY, 4'd0, '0, '0, t0);
        send_request(OP_START, 4'hF, 48'd1000, 48'd1000, t0);
        send_request(OP_STOP, 4'd3, '0, '0, t0);
        send_request(OP_RESUME, 4'd4, '0, '0, t0);
        send_request(OP_TICK, 4'd0, '0, '0, t0);
        send_request(OP_UNUSED_LO, 4'd2, '1, '1, '1);
        send_request(OP_UNUSED_HI, 4'd5, '0, '0, t0);
    endtask

    task automatic test_commands_and_events();
        logic [FIELD_BITS-1:0] t0;
        t0 = 48'd100000;
        send_request(OP_START, 4'd1, '0, '0, t0);
        send_request(OP_START, 4'd1, 48'd2000, '0, t0 + 10);
        send_request(OP_START, 4'd2, 48'd1, 48'd1, t0);
        send_request(OP_START, 4'd3, '1, '1, t0);
        send_request(OP_START, 4'd4, 48'd3000, 48'd10000, t0);
        send_request(OP_STOP, 4'd4, '0, '0, t0 + 500);
        send_request(OP_STOP, 4'd4, '0, '0, t0 + 600);
        send_request(OP_QUERY, 4'd4, '0, '0, t0 + 900);
        send_request(OP_RESUME, 4'd4, '0, '0, t0 + 1500);
        send_request(OP_RESUME, 4'd4, '0, '0, t0 + 1600);
        send_request(OP_QUERY, 4'd4, '0, '0, t0 + 1700);
        // timeouts of 2 and 3, then an interval event from 1; nothing from 4
        send_request(OP_TICK, 4'd0, '0, '0, t0 + 1000);
        send_request(OP_TICK, 4'd0, '0, '0, t0 + 2100);
        // timer 1 falls behind, timer 4 times out
        send_request(OP_TICK, 4'd0, '0, '0, t0 + 20000);
        send_request(OP_QUERY, 4'd2, '0, '0, t0 + 20000);
        // deadline across the wrap of the time counter
        send_request(OP_START, 4'd8, 48'd5, '0, 48'hFFFF_FFFF_FF00);
        send_request(OP_TICK, 4'd0, '0, '0, 48'h0000_0000_0400);
        wait_bank_idle();
    endtask

    task automatic run_random_traffic(input int count);
        int stop_at;
        int pick;
        logic [OP_BITS-1:0] op;
        logic [3:0] num;
        logic [FIELD_BITS-1:0] per;
        logic [FIELD_BITS-1:0] lim;
        logic [FIELD_BITS-1:0] scale;
        stop_at = live_items + count;
        scale = (min_period > 1000) ? FIELD_BITS'(min_period) : 48'd1000;
        while (live_items < stop_at) begin
            pick = $urandom_range(0, 99);
            num  = 4'($urandom_range(1, NUM_TIMERS));
            per  = scale * $urandom_range(1, 4);
            lim  = scale * $urandom_range(3, 12);
            if (pick < 40) begin
                op = OP_TICK;
                if ($urandom_range(0, 19) == 0)
                    clock_us += scale * $urandom_range(3, 10);
                else
                    clock_us += FIELD_BITS'($urandom_range(0, 1500)) * scale / 48'd1000;
            end else begin
                clock_us += FIELD_BITS'($urandom_range(0, 300)) * scale / 48'd1000;
                if (pick < 58) begin
                    op = OP_START;
                    case ($urandom_range(0, 9))
                        0: per = '0;
                        1: per = FIELD_BITS'($urandom_range(0, 32'(min_period)));
                        2: per = FIELD_BITS'({$urandom(), $urandom()});
                        default: ;
                    endcase
                    case ($urandom_range(0, 9))
                        0: lim = '0;
                        1: lim = FIELD_BITS'($urandom_range(0, 32'(min_period)));
                        2: lim = FIELD_BITS'({$urandom(), $urandom()});
                        default: ;
                    endcase
                end else if (pick < 68) begin
                    op = OP_STOP;
                end else if (pick < 78) begin
                    op = OP_RESUME;
                end else if (pick < 90) begin
                    op = OP_QUERY;
                end else if (pick < 95) begin
                    op  = OP_BITS'($urandom_range(OP_START, OP_TICK));
                    num = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(NUM_TIMERS + 1, 15));
                    per = FIELD_BITS'({$urandom(), $urandom()});
                    lim = FIELD_BITS'({$urandom(), $urandom()});
                end else if (pick < 98) begin
                    op  = OP_BITS'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
                    num = 4'($urandom());
                    per = FIELD_BITS'({$urandom(), $urandom()});
                    lim = FIELD_BITS'({$urandom(), $urandom()});
                end else begin
                    // jump of the free-running time to anywhere
                    op = OP_TICK;
                    clock_us = FIELD_BITS'({$urandom(), $urandom()});
                end
            end
            send_request(op, num, per, lim, clock_us);
            if ($urandom_range(0, 49) == 0)
                wait_bank_idle();
        end
        wait_bank_idle();
    endtask

    task automatic test_default_minimum();
        clock_us = 48'd1_000_000;
        run_random_traffic(32);
    endtask

    task automatic test_zero_minimum();
        write_minimum_period('0);
        run_random_traffic(28);
    endtask

    task automatic test_largest_minimum();
        write_minimum_period('1);
        run_random_traffic(28);
    endtask

    task automatic test_wrap_with_odd_minimum();
        write_minimum_period(MIN_BITS'($urandom_range(1, 50000)));
        clock_us = 48'hFFFF_FFFF_FFFF - FIELD_BITS'($urandom_range(0, 200000));
        run_random_traffic(28);
    endtask

    task automatic test_back_to_reset_minimum();
        write_minimum_period(MIN_RESET);
        run_random_traffic(28);
    endtask

    initial begin
        clear_timer_bank();
        clock_us = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_commands_and_events();
        test_default_minimum();
        test_zero_minimum();
        test_largest_minimum();
        test_wrap_with_odd_minimum();
        test_back_to_reset_minimum();
        wait_bank_idle();
        $display("covered %0d requests plus %0d unused opcodes, %0d results checked",
                 live_items, ignored_items, results_checked);
        $display("seen %0d interval and %0d timeout events, %0d late periods skipped",
                 interval_events, timeout_events, late_skips);
        $display("minimum period set %0d times", min_settings);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", error_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
